// ===== rtl/pbac_pkg.sv =====
// Shared constants, types and response curve tables for the pitch bender auto-zero block.
package pbac_pkg;

  localparam int CurveSegments = 32;
  localparam int TblLen        = CurveSegments + 1;
  localparam int CurveCnt      = 3;
  localparam int CenterInt     = 8000;
  localparam int HalfCenterInt = CenterInt / 2;
  localparam int SegBits       = $clog2(CurveSegments);

  localparam logic signed [13:0] DEAD_RANGE     = 14'sd20;
  localparam logic signed [13:0] SMALL_RANGE    = 14'sd200;
  localparam logic signed [13:0] ZERO_RESET     = 14'sd2048;
  localparam logic signed [13:0] LAST_OFF_RESET = 14'sd4096;
  localparam logic signed [13:0] ZERO_STEP      = 14'sd8;
  localparam logic signed [9:0]  RAMP_STEP      = 10'sd8;
  localparam logic [6:0]         TEST_PERIOD    = 7'd80;
  localparam logic [12:0]        GAIN           = 13'd4540;
  localparam logic [25:0]        CLIP_LIMIT     = 26'd8384512;
  localparam logic [13:0]        CENTER         = 14'd8000;
  localparam logic [6:0]         FRAC_ONE       = 7'd64;

  // curve select codes
  localparam logic [1:0] SEL_SOFT   = 2'd0;
  localparam logic [1:0] SEL_NORMAL = 2'd1;
  localparam logic [1:0] SEL_HARD   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCALE,
    ST_CLIP,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_EMIT
  } state_e;

  typedef logic [CurveCnt-1:0][TblLen-1:0][12:0] curve_tbl_t;

  // Curve entry i: 8000*(i/32)*((1-s)+s*(i/32)^2), truncated.
  // All terms are non-negative, so the segment divisions are right shifts.
  function automatic curve_tbl_t build_curves();
    curve_tbl_t t;
    longint     seg2;
    longint     v;
    t    = '0;
    seg2 = longint'(CurveSegments) * CurveSegments;
    for (int i = 0; i < TblLen; i++) begin
      v = (longint'(CenterInt) * i) >> SegBits;
      t[SEL_SOFT][i] = 13'(v);
      v = (longint'(HalfCenterInt) * i * (seg2 + longint'(i) * i)) >> (3 * SegBits);
      t[SEL_NORMAL][i] = 13'(v);
      v = (longint'(CenterInt) * i * i * i) >> (3 * SegBits);
      t[SEL_HARD][i] = 13'(v);
    end
    return t;
  endfunction

  localparam curve_tbl_t CURVE_TBL = build_curves();

endpackage

// ===== rtl/pitch_bender_autozero_curve_top.sv =====
// Pitch bender auto-zero, gain, clip and curve interpolation, with one shared multiplier.
//
// One 12-bit bender sample is taken per request; the tracked zero point is
// subtracted to get a signed offset, and the zero point, settle timer and
// ramp are updated in the cycle after the request. An offset equal to the
// previous one, or one that stays inside the +/-20 dead range, goes from
// UPDATE straight back to IDLE, and new requests are stalled until the
// block is back in IDLE; an offset that falls back into the dead range
// from outside also passes through EMIT, since it may send the center
// value. Offsets outside the dead range run through one 13x13 multiplier
// three times (gain 4540/4096, then the two interpolation weights) in
// SCALE, MUL_A and MUL_B; a clipped value goes from CLIP to EMIT. A result
// leaves through an output register, so the next request is taken while a
// result waits; only a second result that finds the register still stalled
// waits in place. A result is sent only when the offset changed and the new
// bend differs from the last one sent. curve_select (0 soft, 1 normal, 2
// hard) is to be written over its own channel only while the block is idle,
// which the block itself does not enforce; a write of 3 is ignored.
module pitch_bender_autozero_curve_top
  import pbac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] adc_sample_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] pitch_bend_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  curve_select_i
);

  state_e state_q, state_d;

  // control state
  logic [1:0]         sel_q;
  logic signed [13:0] zero_q, zero_d;
  logic signed [13:0] last_off_q;
  logic [13:0]        last_sent_q;
  logic               small_q, small_d;
  logic [6:0]         ticks_q, ticks_d;
  logic               testing_q, testing_d;
  logic               ramping_q, ramping_d;
  logic signed [9:0]  ramp_left_q, ramp_left_d;
  logic               ramp_down_q, ramp_down_d;
  logic               out_valid_q;

  // payload registers
  logic [11:0]        sample_q;
  logic [11:0]        mag_q;
  logic               neg_q;
  logic [25:0]        prod_q;
  logic [25:0]        acc_q;
  logic [4:0]         idx_q;
  logic [5:0]         frac_q;
  logic [12:0]        a_q;
  logic [12:0]        b_q;
  logic [13:0]        val_q;
  logic [13:0]        out_q;

  // update-cycle signals
  logic signed [13:0] off;
  logic               off_small;
  logic               off_pos;
  logic               off_neg;
  logic               last_outside;
  logic signed [9:0]  rl_step;

  // shared multiplier
  logic [12:0]        mul_x;
  logic [12:0]        mul_y;
  logic [25:0]        mul_p;

  logic [19:0]        interp_sum;
  logic [13:0]        shape;
  logic               emit_go;

  assign off          = $signed({2'b00, sample_q}) - zero_q;
  assign off_small    = (off > -SMALL_RANGE) && (off < SMALL_RANGE);
  assign off_pos      = off > DEAD_RANGE;
  assign off_neg      = off < -DEAD_RANGE;
  assign last_outside = (last_off_q > DEAD_RANGE) || (last_off_q < -DEAD_RANGE);

  // Settle timer and ramp: restart the timer on entering the small window,
  // start a ramp after the full period, step the zero while amount remains.
  always_comb begin
    small_d     = off_small;
    ticks_d     = ticks_q;
    testing_d   = testing_q;
    ramping_d   = ramping_q;
    ramp_left_d = ramp_left_q;
    ramp_down_d = ramp_down_q;
    zero_d      = zero_q;
    rl_step     = '0;
    if (off_small && !small_q) begin
      ticks_d   = '0;
      testing_d = 1'b1;
    end else if (!off_small && small_q) begin
      testing_d = 1'b0;
    end
    if (testing_d) begin
      if (ticks_d < TEST_PERIOD) begin
        ticks_d = ticks_d + 7'd1;
      end else begin
        testing_d   = 1'b0;
        ramping_d   = 1'b1;
        ramp_down_d = !(off > 14'sd0);
        ramp_left_d = ramp_down_d ? 10'(-off) : 10'(off);
      end
    end
    if (ramping_d) begin
      rl_step     = ramp_left_d - RAMP_STEP;
      ramp_left_d = rl_step;
      if (rl_step <= 10'sd0) begin
        ramping_d = 1'b0;
      end else begin
        zero_d = ramp_down_d ? (zero_q - ZERO_STEP) : (zero_q + ZERO_STEP);
      end
    end
  end

  // Interpolation: a*(64-frac) + b*frac, then drop six fraction bits.
  assign interp_sum = acc_q[19:0] + prod_q[19:0];
  assign shape      = {2'b00, interp_sum[19:8]} << 2 | {12'd0, interp_sum[7:6]};
  assign emit_go    = !(out_valid_q && out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (off == last_off_q) state_d = ST_IDLE;
        else if (off_pos || off_neg) state_d = ST_SCALE;
        else if (last_outside) state_d = ST_EMIT;
        else state_d = ST_IDLE;
      end
      ST_SCALE: state_d = ST_CLIP;
      ST_CLIP: begin
        if (prod_q > CLIP_LIMIT) state_d = ST_EMIT;
        else state_d = ST_MUL_A;
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_SUM;
      ST_SUM:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (val_q == last_sent_q || emit_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mul_x      = '0;
    mul_y      = '0;
    case (state_q)
      ST_SCALE: begin
        mul_x = {1'b0, mag_q};
        mul_y = GAIN;
      end
      ST_MUL_A: begin
        mul_x = a_q;
        mul_y = {6'd0, FRAC_ONE - {1'b0, frac_q}};
      end
      ST_MUL_B: begin
        mul_x = b_q;
        mul_y = {7'd0, frac_q};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign pitch_bend_o = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= SEL_NORMAL;
      zero_q      <= ZERO_RESET;
      last_off_q  <= LAST_OFF_RESET;
      last_sent_q <= CENTER;
      small_q     <= 1'b0;
      ticks_q     <= '0;
      testing_q   <= 1'b0;
      ramping_q   <= 1'b0;
      ramp_left_q <= '0;
      ramp_down_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // drop writes of the unused code
      if (cfg_valid_i && cfg_ready_o && curve_select_i <= SEL_HARD) begin
        sel_q <= curve_select_i;
      end
      if (state_q == ST_UPDATE) begin
        zero_q      <= zero_d;
        last_off_q  <= off;
        small_q     <= small_d;
        ticks_q     <= ticks_d;
        testing_q   <= testing_d;
        ramping_q   <= ramping_d;
        ramp_left_q <= ramp_left_d;
        ramp_down_q <= ramp_down_d;
      end
      // load a new result, else drop the one just taken
      if (state_q == ST_EMIT && val_q != last_sent_q && emit_go) begin
        out_valid_q <= 1'b1;
        last_sent_q <= val_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) sample_q <= adc_sample_i;
      end
      ST_UPDATE: begin
        neg_q <= off_neg;
        mag_q <= off_neg ? 12'(-DEAD_RANGE - off) : 12'(off - DEAD_RANGE);
        val_q <= CENTER;
      end
      ST_SCALE: prod_q <= mul_p;
      ST_CLIP: begin
        idx_q  <= prod_q[22:18];
        frac_q <= prod_q[17:12];
        a_q    <= CURVE_TBL[sel_q][{1'b0, prod_q[22:18]}];
        val_q  <= neg_q ? (CENTER - CENTER) : (CENTER + CENTER);
      end
      ST_MUL_A: begin
        prod_q <= mul_p;
        b_q    <= CURVE_TBL[sel_q][{1'b0, idx_q} + 6'd1];
      end
      ST_MUL_B: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_SUM: val_q <= neg_q ? (CENTER - shape) : (CENTER + shape);
      ST_EMIT: begin
        if (val_q != last_sent_q && emit_go) out_q <= val_q;
      end
      default: begin
        val_q <= val_q;
      end
    endcase
  end

endmodule

// ===== rtl/pbac_checker.sv =====
// Port-level assertions for the pitch bender auto-zero block, with its bind.
module pbac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [13:0] pitch_bend_o
);

  // a result never leaves the bend range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_bend_o <= 14'd16000)
    else $error("pitch_bend_o above full scale");

  // an accepted request keeps the block busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted on back-to-back cycles");

  // a new result is only loaded while a request is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in work");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pitch_bend_o)))
    else $error("stalled result changed");

endmodule

bind pitch_bender_autozero_curve_top pbac_checker u_pbac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pitch_bend_o (pitch_bend_o)
);

// ===== bench/pitch_bender_autozero_curve_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the pitch bender auto-zero, gain and curve block.
module pitch_bender_autozero_curve_top_test;
  import pbac_pkg::*;

  // Bend arithmetic, kept apart from the RTL's own constants.
  localparam int BendCenter  = 8000;
  localparam int DeadWin     = 20;
  localparam int NearWin     = 200;
  localparam int SettleTicks = 80;
  localparam int RampStride  = 8;
  localparam int GainNum     = 4540;
  localparam int GainShift   = 12;
  localparam int ClipScaled  = 2047 * 4096;
  localparam int Segs        = 32;
  localparam int FracBits    = 6;
  localparam int SampleMax   = 4095;
  // Run control.
  localparam int DrainCycles = 16;
  localparam int HoldLen     = 300;
  localparam int CycleLimit  = 200000;
  // A select the block must ignore.
  localparam logic [1:0] SEL_IGNORED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [11:0] adc_sample_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [13:0] pitch_bend_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  curve_select_i;

  pitch_bender_autozero_curve_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .adc_sample_i   (adc_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pitch_bend_o   (pitch_bend_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .curve_select_i (curve_select_i)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bender state as the block should hold it.
  int          bend_curve [3][Segs+1];
  logic [1:0]  curve_sel;
  int          zero_pt;
  int          prev_off;
  int          last_bend;
  bit          near_zero;
  int          settle_cnt;
  bit          settling;
  bit          ramp_on;
  int          ramp_amt;
  bit          ramp_neg;

  // Bends still owed by the block, oldest first.
  logic [13:0] bend_expected [$];
  logic [13:0] bend_want;

  int          items_sent;
  int          bends_checked;
  int          bend_errors;
  int          ramps_started;
  int          cycle_count;
  int          last_sample;
  int          hold_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;

  // Map a magnitude beyond the dead range to 0..8000 through the active curve.
  function automatic int curve_lookup(input int mag);
    int scaled;
    int frac;
    int idx;
    scaled = mag * GainNum;
    if (scaled > ClipScaled) return BendCenter;
    scaled = scaled >>> GainShift;
    frac   = scaled & ((1 << FracBits) - 1);
    idx    = (scaled >> FracBits) & (Segs - 1);
    return (bend_curve[curve_sel][idx] * ((1 << FracBits) - frac) +
            bend_curve[curve_sel][idx + 1] * frac) >>> FracBits;
  endfunction

  function automatic int pin_sample(input int v);
    if (v < 0) return 0;
    if (v > SampleMax) return SampleMax;
    return v;
  endfunction

  // Advance the bender state by one accepted sample; queue the bend it sends.
  task automatic advance_bender(input logic [11:0] sample);
    int off;
    int bend;
    bit fresh;
    off   = int'(sample) - zero_pt;
    fresh = 1'b0;
    bend  = BendCenter;
    if (off > -NearWin && off < NearWin) begin
      if (!near_zero) begin
        settle_cnt = 0;
        settling   = 1'b1;
      end
      near_zero = 1'b1;
    end else begin
      if (near_zero) settling = 1'b0;
      near_zero = 1'b0;
    end
    if (settling) begin
      if (settle_cnt < SettleTicks) begin
        settle_cnt++;
      end else begin
        settling = 1'b0;
        ramp_on  = 1'b1;
        ramp_neg = !(off > 0);
        ramp_amt = ramp_neg ? -off : off;
        ramps_started++;
      end
    end
    // The first step comes off the ramp amount on the tick the ramp starts.
    if (ramp_on) begin
      ramp_amt -= RampStride;
      if (ramp_amt <= 0) ramp_on = 1'b0;
      else zero_pt += ramp_neg ? -RampStride : RampStride;
    end
    if (off != prev_off) begin
      if (off > DeadWin) begin
        bend  = BendCenter + curve_lookup(off - DeadWin);
        fresh = 1'b1;
      end else if (off < -DeadWin) begin
        bend  = BendCenter - curve_lookup(-DeadWin - off);
        fresh = 1'b1;
      end else if (prev_off > DeadWin || prev_off < -DeadWin) begin
        fresh = 1'b1;
      end
      prev_off = off;
    end
    items_sent++;
    if (fresh && bend != last_bend) begin
      last_bend = bend;
      bend_expected.push_back(14'(bend));
    end
  endtask

  // Offer one sample request; enter and leave at a falling edge.
  task automatic push_sample(input int sample);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid_i   = 1'b1;
    adc_sample_i = 12'(sample);
    last_sample  = sample;
    do @(posedge clk); while (in_stall_o);
    advance_bender(12'(sample));
    @(negedge clk);
    in_valid_i = 1'b0;
  endtask

  // Wait for every owed bend, then let a dead-range request finish too.
  task automatic settle_block();
    while (bend_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_curve(input logic [1:0] sel);
    settle_block();
    cfg_valid_i    = 1'b1;
    curve_select_i = sel;
    do @(posedge clk); while (!cfg_ready_o);
    // A select of three leaves the previous curve in place.
    if (sel <= SEL_HARD) curve_sel = sel;
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    bend_errors++;
    if (bend_errors <= 10)
      $display("%0t ns pitch_bend %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Full-scale ends, dead-range edges, clip edges and unchanged offsets.
  task automatic test_extremes();
    int offs [] = '{0, 2047, -2048, 0, 0, 20, 21, -21, -20, 1866, 1867,
                    -1866, -1867, 1866};
    foreach (offs[k]) push_sample(pin_sample(zero_pt + offs[k]));
    push_sample(0);
    push_sample(SampleMax);
  endtask

  // Each curve, plus a select the block must drop.
  task automatic test_curves();
    logic [1:0] sels [] = '{SEL_SOFT, SEL_HARD, SEL_IGNORED, SEL_NORMAL};
    int         offs [] = '{500, -900, 1300, 0};
    foreach (sels[s]) begin
      write_curve(sels[s]);
      foreach (offs[k]) push_sample(pin_sample(zero_pt + offs[k]));
    end
  endtask

  // Rest near zero long enough to start a ramp, both ways.
  task automatic test_autozero();
    int base;
    base = pin_sample(zero_pt + 150);
    for (int k = 0; k < 90; k++) push_sample(base + (k & 1));
    for (int k = 0; k < 20; k++) push_sample(base);
    // Leave the near-zero window so the settle timer restarts.
    push_sample(pin_sample(zero_pt - 400));
    // A ramp of exactly one step ends at once without moving the zero.
    base = pin_sample(zero_pt - 8);
    for (int k = 0; k < 85; k++) push_sample(base);
  endtask

  // Hold the result side for a long stretch while requests keep coming.
  task automatic test_backpressure();
    bit idle_was;
    idle_was   = tx_idle_en;
    tx_idle_en = 1'b0;
    settle_block();
    hold_cycles = HoldLen;
    for (int k = 0; k < 16; k++) push_sample((k & 1) ? SampleMax : 0);
    tx_idle_en = idle_was;
  endtask

  // Bender motion: sweeps, rests that start ramps, broken rests, noise,
  // repeats and dead-range wiggle.
  task automatic test_random_motion(input int n_items);
    int start;
    int kind;
    int target;
    int from;
    int steps;
    int base;
    int len;
    int off0;
    start = items_sent;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          from   = last_sample;
          target = $urandom_range(0, SampleMax);
          steps  = $urandom_range(4, 30);
          for (int k = 1; k <= steps; k++)
            push_sample(from + (target - from) * k / steps);
        end
        4, 5: begin
          if ($urandom_range(0, 1) == 1) off0 = int'($urandom_range(0, 32)) - 16;
          else if ($urandom_range(0, 1) == 1) off0 = int'($urandom_range(21, 196));
          else off0 = -int'($urandom_range(21, 196));
          base = pin_sample(zero_pt + off0);
          // A full rest outlasts the settle time; a broken one jumps away early.
          len  = (kind == 4) ? $urandom_range(82, 110) : $urandom_range(10, 70);
          for (int k = 0; k < len; k++)
            push_sample(pin_sample(base + int'($urandom_range(0, 2)) - 1));
          if (kind == 5) push_sample($urandom_range(0, SampleMax));
        end
        6, 7: begin
          len = $urandom_range(3, 12);
          for (int k = 0; k < len; k++) push_sample($urandom_range(0, SampleMax));
        end
        8: begin
          len = $urandom_range(2, 6);
          for (int k = 0; k < len; k++) push_sample(last_sample);
        end
        default: begin
          len = $urandom_range(2, 8);
          for (int k = 0; k < len; k++)
            push_sample(pin_sample(zero_pt + int'($urandom_range(0, 2 * DeadWin)) - DeadWin));
        end
      endcase
    end
  endtask

  // Result side: stall in random bursts, or for a long counted hold.
  always begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      while (hold_cycles > 0) begin
        @(negedge clk);
        hold_cycles--;
      end
      out_stall_i = 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall_i = 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      out_stall_i = 1'b0;
    end
  end

  // Check every bend that leaves the block against the oldest one owed.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bends_checked++;
      if (bend_expected.size() == 0) begin
        note_mismatch("with nothing owed", -1, int'(pitch_bend_o));
      end else begin
        bend_want = bend_expected.pop_front();
        if (pitch_bend_o !== bend_want)
          note_mismatch("mismatch", int'(bend_want), int'(pitch_bend_o));
      end
    end
  end

  // Watchdog: drop out if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bends still owed", cycle_count,
               bend_expected.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value from time zero.
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    adc_sample_i   = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    curve_select_i = SEL_NORMAL;
    hold_cycles    = 0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    items_sent     = 0;
    bends_checked  = 0;
    bend_errors    = 0;
    ramps_started  = 0;
    cycle_count    = 0;

    // Build the three curves: linear, half linear plus half cubic, cubic.
    for (int i = 0; i <= Segs; i++) begin
      bend_curve[SEL_SOFT][i]   = (BendCenter * i) / Segs;
      bend_curve[SEL_NORMAL][i] = int'((longint'(BendCenter / 2) * i *
                                        (Segs * Segs + i * i)) / (Segs * Segs * Segs));
      bend_curve[SEL_HARD][i]   = int'((longint'(BendCenter) * i * i * i) /
                                       (Segs * Segs * Segs));
    end

    // Reset values of the tracked state.
    curve_sel   = SEL_NORMAL;
    zero_pt     = 2048;
    prev_off    = 4096;
    last_bend   = BendCenter;
    near_zero   = 1'b0;
    settle_cnt  = 0;
    settling    = 1'b0;
    ramp_on     = 1'b0;
    ramp_amt    = 0;
    ramp_neg    = 1'b0;
    last_sample = 2048;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Directed part runs with random idling on both sides.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_extremes();
    test_curves();
    test_autozero();
    test_backpressure();

    // Random motion under each curve, extremes included.
    write_curve(SEL_NORMAL);
    test_random_motion(150);
    write_curve(SEL_SOFT);
    test_random_motion(100);
    write_curve(SEL_HARD);
    test_random_motion(100);

    // Last stretch runs at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_curve(SEL_IGNORED);
    test_random_motion(100);

    settle_block();
    $display("covered %0d sample requests and %0d bends over soft, normal and hard curves,",
             items_sent, bends_checked);
    $display("with %0d auto-zero ramps, a dropped select and a %0d-cycle output hold",
             ramps_started, HoldLen);
    if (bend_errors == 0 && bend_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
